FILE: sv/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the sky pattern pixel generator
// Field widths, configuration codes, pattern codes and the stage records
// that travel between the front end, the divider and the exponential unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned D2_W      = 25;
  localparam int unsigned S2_W      = 32;
  localparam int unsigned REM_W     = S2_W + 1;
  localparam int unsigned XQ_W      = 20;
  localparam int unsigned SQ36_W    = 36;
  localparam int unsigned Q30_FRAC  = 30;
  localparam int unsigned Q30_W     = Q30_FRAC + 1;
  localparam int unsigned F_W       = XQ_W + 10;
  localparam int unsigned SERIES_TERMS = 20;
  localparam int unsigned DIV_STAGES   = XQ_W;

  localparam int unsigned DEF_MAX_DIM       = 4096;
  localparam int unsigned DEF_OUT_FRAC_BITS = 15;

  // exponent limit 12.0 in Q16
  localparam logic [XQ_W-1:0]  EXP_CUTOFF = 20'd786432;
  localparam logic [Q30_W-1:0] Q30_ONE    = 31'h4000_0000;

  typedef enum logic [2:0] {
    PAT_POINT     = 3'd0,
    PAT_UNIFORM   = 3'd1,
    PAT_GAUSS     = 3'd2,
    PAT_TWO_POINT = 3'd3,
    PAT_RING      = 3'd4
  } pattern_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_SIGMA  = 3'd3,
    CFG_RADIUS = 3'd4,
    CFG_RWIDTH = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
  } coord_t;

  typedef struct packed {
    logic [VAL_W-1:0] pixel_value;
  } value_t;

  // configuration as seen by the datapath, clamped and pre-squared
  typedef struct packed {
    logic [2:0]        mode;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  width;
    logic              sigma_zero;
    logic [S2_W-1:0]   s2;
    logic [SQ36_W-1:0] s2x12;
    logic [SQ36_W-1:0] hi2;
    logic [SQ36_W-1:0] lo2;
    logic              lo_pos;
  } cfg_t;

  typedef struct packed {
    logic             use_exp;
    logic [VAL_W-1:0] fixed_val;
    logic [REM_W-1:0] rem;
  } fd_t;

  typedef struct packed {
    logic             use_exp;
    logic [VAL_W-1:0] fixed_val;
    logic [XQ_W-1:0]  xq;
  } de_t;

  typedef struct packed {
    logic             use_exp;
    logic [VAL_W-1:0] fixed_val;
    logic [F_W-1:0]   f;
    logic [Q30_W-1:0] term;
    logic [Q30_W-1:0] sum;
  } exp_t;

  typedef struct packed {
    logic             use_exp;
    logic [VAL_W-1:0] fixed_val;
    logic [Q30_W-1:0] y;
  } sq_t;

  function automatic logic [VAL_W-1:0] one_value(input int unsigned frac);
    return VAL_W'((64'd1 << frac) & 64'hFFFF);
  endfunction

endpackage

`default_nettype wire

FILE: sv/ssp_stream_if.sv
// ----------------------------------------------------------------------------
// ssp_stream_if: valid/ready stream channel
// Carries one payload per transaction; a transaction completes on a rising
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front: coordinate front end
// Centre offsets, squared distance and the decision of every pattern that
// needs no exponential, over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_front #(
  parameter int unsigned OUT_FRAC_BITS = ssp_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           in_valid_i,
  input  ssp_pkg::coord_t px_i,
  input  ssp_pkg::cfg_t  cfg_i,
  output logic           out_valid_o,
  output ssp_pkg::fd_t   fd_o
);
  import ssp_pkg::*;

  localparam logic [VAL_W-1:0] ONE_VAL = one_value(OUT_FRAC_BITS);

  // stage 1: offsets and position tests
  logic [COORD_W-1:0] cy, cx, dy_d, dx_d;
  logic [COORD_W-2:0] cy_half;
  logic [COORD_W+1:0] cy3;
  logic               outside_d, pt_d, two_d;

  assign cy      = cfg_i.height[DIM_W-1:1];
  assign cx      = cfg_i.width[DIM_W-1:1];
  assign cy_half = cy[COORD_W-1:1];
  assign cy3     = {2'b00, cy} + {1'b0, cy, 1'b0};

  assign outside_d = ({1'b0, px_i.pixel_row} >= cfg_i.height) ||
                     ({1'b0, px_i.pixel_col} >= cfg_i.width);
  assign dy_d = (px_i.pixel_row >= cy) ? px_i.pixel_row - cy : cy - px_i.pixel_row;
  assign dx_d = (px_i.pixel_col >= cx) ? px_i.pixel_col - cx : cx - px_i.pixel_col;
  assign pt_d = (px_i.pixel_row == cy) && (px_i.pixel_col == cx);
  assign two_d = (px_i.pixel_col == cx) &&
                 ((px_i.pixel_row == {1'b0, cy_half}) ||
                  ({1'b0, px_i.pixel_row} == cy3[COORD_W+1:1]));

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               out1_q, pt1_q, two1_q;
  logic [COORD_W-1:0] dy1_q, dx1_q;
  logic               out2_q, pt2_q, two2_q;
  logic [2*COORD_W-1:0] sqy2_q, sqx2_q;
  logic               out3_q, pt3_q, two3_q;
  logic [D2_W-1:0]    d2_3_q;
  fd_t                fd_d, fd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out1_q <= outside_d;
      pt1_q  <= pt_d;
      two1_q <= two_d;
      dy1_q  <= dy_d;
      dx1_q  <= dx_d;
      // stage 2: squares
      out2_q <= out1_q;
      pt2_q  <= pt1_q;
      two2_q <= two1_q;
      sqy2_q <= (2*COORD_W)'(dy1_q) * (2*COORD_W)'(dy1_q);
      sqx2_q <= (2*COORD_W)'(dx1_q) * (2*COORD_W)'(dx1_q);
      // stage 3: squared distance
      out3_q <= out2_q;
      pt3_q  <= pt2_q;
      two3_q <= two2_q;
      d2_3_q <= D2_W'(sqy2_q) + D2_W'(sqx2_q);
      // stage 4: pattern decision
      fd_q   <= fd_d;
    end
  end

  // stage 4 compares: ring in 1/32 pixel squared, gaussian cutoff
  logic [SQ36_W-1:0] scaled;
  logic [SQ36_W-1:0] d2x128;
  logic              cut, ring_hit;

  assign scaled   = {1'b0, d2_3_q, 10'b0};
  assign d2x128   = {4'b0, d2_3_q, 7'b0};
  assign cut      = d2x128 >= cfg_i.s2x12;
  assign ring_hit = (!cfg_i.lo_pos || (scaled >= cfg_i.lo2)) && (scaled <= cfg_i.hi2);

  always_comb begin
    fd_d.rem       = REM_W'({d2_3_q, 3'b000});
    fd_d.use_exp   = 1'b0;
    fd_d.fixed_val = '0;
    if (!out3_q) begin
      case (cfg_i.mode)
        PAT_POINT: begin
          if (pt3_q) fd_d.fixed_val = ONE_VAL;
        end
        PAT_UNIFORM: begin
          fd_d.fixed_val = ONE_VAL;
        end
        PAT_GAUSS: begin
          if (cfg_i.sigma_zero) begin
            if (d2_3_q == '0) fd_d.fixed_val = ONE_VAL;
          end else if (!cut) begin
            fd_d.use_exp = 1'b1;
          end
        end
        PAT_TWO_POINT: begin
          if (two3_q) fd_d.fixed_val = ONE_VAL;
        end
        PAT_RING: begin
          if (ring_hit) fd_d.fixed_val = ONE_VAL;
        end
        default: begin
          fd_d.fixed_val = '0;
        end
      endcase
    end
  end

  assign out_valid_o = v4_q;
  assign fd_o        = fd_q;

endmodule

`default_nettype wire

FILE: sv/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div: pipelined exponent divider
// Restoring division of d2 * 2^23 by sigma^2, one quotient bit per stage.
// The front end guarantees the quotient fits, so the remainder starts at
// d2 * 8 and only shifts in zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  input  ssp_pkg::fd_t               fd_i,
  input  logic [ssp_pkg::S2_W-1:0]   s2_i,
  output logic                       out_valid_o,
  output ssp_pkg::de_t               de_o
);
  import ssp_pkg::*;

  logic             vld_s [DIV_STAGES+1];
  logic             use_s [DIV_STAGES+1];
  logic [VAL_W-1:0] fix_s [DIV_STAGES+1];
  logic [REM_W-1:0] rem_s [DIV_STAGES+1];
  logic [XQ_W-1:0]  q_s   [DIV_STAGES+1];

  assign vld_s[0] = in_valid_i;
  assign use_s[0] = fd_i.use_exp;
  assign fix_s[0] = fd_i.fixed_val;
  assign rem_s[0] = fd_i.rem;
  assign q_s[0]   = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    logic [REM_W-1:0] r2;
    logic             ge;

    assign r2 = {rem_s[i][REM_W-2:0], 1'b0};
    assign ge = r2 >= {1'b0, s2_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        use_s[i+1] <= use_s[i];
        fix_s[i+1] <= fix_s[i];
        rem_s[i+1] <= ge ? r2 - {1'b0, s2_i} : r2;
        q_s[i+1]   <= {q_s[i][XQ_W-2:0], ge};
      end
    end
  end

  assign out_valid_o  = vld_s[DIV_STAGES];
  assign de_o.use_exp   = use_s[DIV_STAGES];
  assign de_o.fixed_val = fix_s[DIV_STAGES];
  assign de_o.xq        = q_s[DIV_STAGES];

  a_quot_below_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_s[DIV_STAGES] && use_s[DIV_STAGES] |-> q_s[DIV_STAGES] < EXP_CUTOFF)
    else $error("exponent quotient reached the cutoff");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_s[DIV_STAGES] && use_s[DIV_STAGES] |-> rem_s[DIV_STAGES] < {1'b0, s2_i})
    else $error("division remainder not below sigma squared");

endmodule

`default_nettype wire

FILE: sv/ssp_exp.sv
// ----------------------------------------------------------------------------
// ssp_exp: pipelined exponential unit
// Taylor series of e^-(x/16) in Q30, two stages per term (product with the
// argument, then division by the term index through a reciprocal), four
// squaring stages, rounding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_exp #(
  parameter int unsigned OUT_FRAC_BITS = ssp_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  ssp_pkg::de_t              de_i,
  output logic                      out_valid_o,
  output logic [ssp_pkg::VAL_W-1:0] value_o
);
  import ssp_pkg::*;

  localparam int unsigned SER_STAGES = 2 * SERIES_TERMS;
  localparam int unsigned SQ_STAGES  = 4;
  localparam int unsigned PROD_W     = Q30_W + F_W;
  localparam int unsigned SQP_W      = 2 * Q30_W;
  localparam bit          LAST_ODD   = (SERIES_TERMS % 2) == 1;

  logic ser_v [SER_STAGES+1];
  exp_t ser_s [SER_STAGES+1];

  assign ser_v[0]           = in_valid_i;
  assign ser_s[0].use_exp   = de_i.use_exp;
  assign ser_s[0].fixed_val = de_i.fixed_val;
  assign ser_s[0].f         = {de_i.xq, 10'b0};
  assign ser_s[0].term      = Q30_ONE;
  assign ser_s[0].sum       = Q30_ONE;

  for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
    localparam int unsigned IA = 2 * n - 2;
    localparam int unsigned IB = 2 * n - 1;
    localparam int unsigned L  = $clog2(n);
    localparam int unsigned K  = Q30_W + L;
    localparam logic [32:0] M  = 33'(((64'd1 << K) + 64'(n) - 64'd1) / 64'(n));
    localparam bit PREV_ODD    = ((n - 1) % 2) == 1;

    logic [PROD_W-1:0] mul_a;
    logic [63:0]       mul_b;
    exp_t              a_d, b_d;

    assign mul_a = PROD_W'(ser_s[IA].term) * PROD_W'(ser_s[IA].f);
    assign mul_b = 64'(ser_s[IB].term) * 64'(M);

    // fold the previous term into the sum while the next product forms
    always_comb begin
      a_d      = ser_s[IA];
      a_d.term = mul_a[Q30_FRAC+Q30_W-1:Q30_FRAC];
      if (n == 1) begin
        a_d.sum = ser_s[IA].sum;
      end else if (PREV_ODD) begin
        a_d.sum = ser_s[IA].sum - ser_s[IA].term;
      end else begin
        a_d.sum = ser_s[IA].sum + ser_s[IA].term;
      end
    end

    always_comb begin
      b_d      = ser_s[IB];
      b_d.term = Q30_W'(mul_b >> K);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ser_v[IB]   <= 1'b0;
        ser_v[IB+1] <= 1'b0;
      end else if (adv_i) begin
        ser_v[IB]   <= ser_v[IA];
        ser_v[IB+1] <= ser_v[IB];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ser_s[IB]   <= a_d;
        ser_s[IB+1] <= b_d;
      end
    end
  end

  // last term, then square four times
  logic sq_v [SQ_STAGES+1];
  sq_t  sq_s [SQ_STAGES+1];
  sq_t  sq0_d;

  always_comb begin
    sq0_d.use_exp   = ser_s[SER_STAGES].use_exp;
    sq0_d.fixed_val = ser_s[SER_STAGES].fixed_val;
    if (LAST_ODD) begin
      sq0_d.y = ser_s[SER_STAGES].sum - ser_s[SER_STAGES].term;
    end else begin
      sq0_d.y = ser_s[SER_STAGES].sum + ser_s[SER_STAGES].term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (adv_i) begin
      sq_v[0] <= ser_v[SER_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) sq_s[0] <= sq0_d;
  end

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_square
    logic [SQP_W-1:0] prod;
    sq_t              s_d;

    assign prod = SQP_W'(sq_s[j].y) * SQP_W'(sq_s[j].y);

    always_comb begin
      s_d   = sq_s[j];
      s_d.y = prod[Q30_FRAC+Q30_W-1:Q30_FRAC];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[j+1] <= 1'b0;
      end else if (adv_i) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) sq_s[j+1] <= s_d;
    end
  end

  // round half up to the output format and pick the result
  logic [SQP_W-1:0] rnd;
  logic [VAL_W-1:0] val_d, value_q;
  logic             out_v_q;

  assign rnd   = (SQP_W'(sq_s[SQ_STAGES].y) << OUT_FRAC_BITS) +
                 (SQP_W'(1) << (Q30_FRAC - 1));
  assign val_d = sq_s[SQ_STAGES].use_exp ? rnd[Q30_FRAC+VAL_W-1:Q30_FRAC]
                                         : sq_s[SQ_STAGES].fixed_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      out_v_q <= sq_v[SQ_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) value_q <= val_d;
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;

  a_series_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[0] && sq_s[0].use_exp |-> sq_s[0].y <= Q30_ONE)
    else $error("series sum above one");

endmodule

`default_nettype wire

FILE: sv/synthetic_sky_pattern_pixel.sv
// ----------------------------------------------------------------------------
// synthetic_sky_pattern_pixel: synthetic sky test-pattern pixel generator
// Returns the Q1.15 value of one pixel coordinate for the selected pattern.
// ----------------------------------------------------------------------------
// One coordinate enters per clock and flows through the pipeline: four
// front-end stages (offsets, squares, distance, pattern decision), twenty
// divider stages that form the gaussian exponent one quotient bit at a time,
// and 46 exponential stages (two per series term for twenty terms, the last
// term, four squarings, rounding into the output register). The whole
// pipeline holds while a result waits at the output, so the stream runs at
// one pixel per clock whenever the consumer takes every result. Write the
// configuration only while no pixel is in flight; derived squares are
// registered after a write, twelve sigma squared behind sigma squared. After
// reset the pattern is a single centre point of a 256 by 256 image.
// ----------------------------------------------------------------------------
`default_nettype none

module synthetic_sky_pattern_pixel #(
  parameter int unsigned MAX_DIM       = ssp_pkg::DEF_MAX_DIM,
  parameter int unsigned OUT_FRAC_BITS = ssp_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssp_pkg::CFG_W-1:0]     cfg_data_i,
  ssp_stream_if.sink                    coord_i,
  ssp_stream_if.source                  value_o
);
  import ssp_pkg::*;

  localparam int unsigned DIM_REG_MAX = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    DIM_W'((MAX_DIM > DIM_REG_MAX) ? DIM_REG_MAX : MAX_DIM);

  // configuration registers
  logic [2:0]       mode_q;
  logic [DIM_W-1:0] height_q, width_q;
  logic [15:0]      sigma_q, radius_q, rwidth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= PAT_POINT;
      height_q <= 13'd256;
      width_q  <= 13'd256;
      sigma_q  <= 16'd320;
      radius_q <= 16'd640;
      rwidth_q <= 16'd48;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[2:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SIGMA:  sigma_q  <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_RWIDTH: rwidth_q <= cfg_data_i;
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  // derived values, recomputed every cycle from the registers
  logic signed [17:0] lo;
  logic [17:0]        hi;
  logic [DIM_W-1:0]   h_q, w_q;
  logic [S2_W-1:0]    s2_q;
  logic [SQ36_W-1:0]  s2x12_q, hi2_q, lo2_q;
  logic               lo_pos_q;

  assign lo = $signed({1'b0, radius_q, 1'b0}) - $signed({2'b00, rwidth_q});
  assign hi = {1'b0, radius_q, 1'b0} + {2'b00, rwidth_q};

  always_ff @(posedge clk_i) begin
    h_q      <= (height_q > DIM_CAP) ? DIM_CAP : height_q;
    w_q      <= (width_q > DIM_CAP) ? DIM_CAP : width_q;
    s2_q     <= {16'b0, sigma_q} * {16'b0, sigma_q};
    s2x12_q  <= ({4'b0, s2_q} << 3) + ({4'b0, s2_q} << 2);
    hi2_q    <= {18'b0, hi} * {18'b0, hi};
    lo2_q    <= {19'b0, lo[16:0]} * {19'b0, lo[16:0]};
    lo_pos_q <= !lo[17] && (lo != 18'sd0);
  end

  cfg_t cfg;

  always_comb begin
    cfg.mode       = mode_q;
    cfg.height     = h_q;
    cfg.width      = w_q;
    cfg.sigma_zero = (sigma_q == 16'd0);
    cfg.s2         = s2_q;
    cfg.s2x12      = s2x12_q;
    cfg.hi2        = hi2_q;
    cfg.lo2        = lo2_q;
    cfg.lo_pos     = lo_pos_q;
  end

  // hold every stage while the output transaction is pending
  logic adv;
  assign adv           = !value_o.valid || value_o.ready;
  assign coord_i.ready = adv;

  logic             fd_valid, de_valid, out_valid;
  fd_t              fd;
  de_t              de;
  logic [VAL_W-1:0] out_value;

  ssp_front #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (coord_i.valid),
    .px_i        (coord_i.data),
    .cfg_i       (cfg),
    .out_valid_o (fd_valid),
    .fd_o        (fd)
  );

  ssp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (fd_valid),
    .fd_i        (fd),
    .s2_i        (s2_q),
    .out_valid_o (de_valid),
    .de_o        (de)
  );

  ssp_exp #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_exp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (de_valid),
    .de_i        (de),
    .out_valid_o (out_valid),
    .value_o     (out_value)
  );

  assign value_o.valid            = out_valid;
  assign value_o.data.pixel_value = out_value;

  a_value_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_o.valid |-> (OUT_FRAC_BITS >= VAL_W) ||
                      (value_o.data.pixel_value <= one_value(OUT_FRAC_BITS)))
    else $error("pixel value above one");

endmodule

`default_nettype wire
